### rtl/rpn_alu_pkg.sv
// shared constants, codes and interface types for the rpn integer unit
package rpn_alu_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int DATA_W      = 32;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int DEPTH_W     = 5;
   localparam int STEPS       = DATA_W;
   localparam int STEP_W      = $clog2(STEPS);

   localparam logic [DATA_W-1:0] INT_MIN_MAG = {1'b1, {(DATA_W-1){1'b0}}};

   typedef enum logic [2:0] {
      CMD_PUSH = 3'd0,
      CMD_ADD  = 3'd1,
      CMD_SUB  = 3'd2,
      CMD_MUL  = 3'd3,
      CMD_DIV  = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_FEW     = 3'd1,
      ST_OVER    = 3'd2,
      ST_UNDER   = 3'd3,
      ST_DIVZERO = 3'd4,
      ST_UNKNOWN = 3'd5,
      ST_FULL    = 3'd6
   } status_type;

   typedef struct packed {
      logic              start;
      cmd_type           op;
      logic [DATA_W-1:0] left;
      logic [DATA_W-1:0] right;
   } alu_req_type;

   typedef struct packed {
      logic              done;
      status_type        status;
      logic [DATA_W-1:0] value;
   } alu_rsp_type;

endpackage

### rtl/rpn_alu_serial.sv
// bit-serial add, subtract, multiply and divide unit with range checks
module rpn_alu_serial (
   input  logic                      clock,
   input  logic                      reset,
   input  rpn_alu_pkg::alu_req_type  alu_req,
   output rpn_alu_pkg::alu_rsp_type  alu_rsp
);

   typedef enum logic [2:0] {
      A_IDLE = 3'b001,
      A_RUN  = 3'b010,
      A_FIX  = 3'b100
   } astate_type;

   astate_type                          state_ff, state_in;
   rpn_alu_pkg::cmd_type                op_ff, op_in;
   logic [rpn_alu_pkg::DATA_W-1:0]      acc_ff, acc_in;
   logic [rpn_alu_pkg::DATA_W-1:0]      lo_ff, lo_in;
   logic [rpn_alu_pkg::DATA_W-1:0]      rhs_ff, rhs_in;
   logic                                carry_ff, carry_in;
   logic                                lsgn_ff, lsgn_in;
   logic                                bsgn_ff, bsgn_in;
   logic [rpn_alu_pkg::STEP_W-1:0]      cnt_ff, cnt_in;

   logic [rpn_alu_pkg::DATA_W-1:0]      l_mag, r_mag;
   logic                                is_sub, add_b, add_s;
   logic [rpn_alu_pkg::DATA_W:0]        mul_sum;
   logic [rpn_alu_pkg::DATA_W-1:0]      div_shl;
   logic                                neg, big, fits;

   assign is_sub = (op_ff == rpn_alu_pkg::CMD_SUB);
   assign l_mag  = alu_req.left[rpn_alu_pkg::DATA_W-1] ? (~alu_req.left + 1'b1) : alu_req.left;
   assign r_mag  = alu_req.right[rpn_alu_pkg::DATA_W-1] ? (~alu_req.right + 1'b1) : alu_req.right;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      acc_in   = acc_ff;
      lo_in    = lo_ff;
      rhs_in   = rhs_ff;
      carry_in = carry_ff;
      lsgn_in  = lsgn_ff;
      bsgn_in  = bsgn_ff;
      cnt_in   = cnt_ff;
      add_b    = rhs_ff[0] ^ is_sub;
      add_s    = lo_ff[0] ^ add_b ^ carry_ff;
      mul_sum  = {1'b0, acc_ff} + (lo_ff[0] ? {1'b0, rhs_ff} : '0);
      div_shl  = {acc_ff[rpn_alu_pkg::DATA_W-2:0], lo_ff[rpn_alu_pkg::DATA_W-1]};
      unique case (state_ff)
         A_IDLE: begin
            if (alu_req.start) begin
               op_in    = alu_req.op;
               cnt_in   = '0;
               acc_in   = '0;
               carry_in = (alu_req.op == rpn_alu_pkg::CMD_SUB);
               lsgn_in  = alu_req.left[rpn_alu_pkg::DATA_W-1];
               bsgn_in  = alu_req.right[rpn_alu_pkg::DATA_W-1]
                          ^ (alu_req.op == rpn_alu_pkg::CMD_SUB);
               if ((alu_req.op == rpn_alu_pkg::CMD_MUL) ||
                   (alu_req.op == rpn_alu_pkg::CMD_DIV)) begin
                  lo_in  = l_mag;
                  rhs_in = r_mag;
               end else begin
                  lo_in  = alu_req.left;
                  rhs_in = alu_req.right;
               end
               state_in = A_RUN;
            end
         end
         A_RUN: begin
            unique case (op_ff)
               rpn_alu_pkg::CMD_ADD, rpn_alu_pkg::CMD_SUB: begin
                  // one sum bit per cycle, lsb first, sum fills from the top
                  carry_in = (lo_ff[0] & add_b) | (lo_ff[0] & carry_ff) | (add_b & carry_ff);
                  lo_in    = {add_s, lo_ff[rpn_alu_pkg::DATA_W-1:1]};
                  rhs_in   = {1'b0, rhs_ff[rpn_alu_pkg::DATA_W-1:1]};
               end
               rpn_alu_pkg::CMD_MUL: begin
                  acc_in = mul_sum[rpn_alu_pkg::DATA_W:1];
                  lo_in  = {mul_sum[0], lo_ff[rpn_alu_pkg::DATA_W-1:1]};
               end
               rpn_alu_pkg::CMD_DIV: begin
                  // restoring division, one quotient bit per cycle
                  if (div_shl >= rhs_ff) begin
                     acc_in = div_shl - rhs_ff;
                     lo_in  = {lo_ff[rpn_alu_pkg::DATA_W-2:0], 1'b1};
                  end else begin
                     acc_in = div_shl;
                     lo_in  = {lo_ff[rpn_alu_pkg::DATA_W-2:0], 1'b0};
                  end
               end
               default: ;
            endcase
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == rpn_alu_pkg::STEP_W'(rpn_alu_pkg::STEPS - 1)) begin
               state_in = A_FIX;
            end
         end
         A_FIX: begin
            state_in = A_IDLE;
         end
         default: begin
            state_in = A_IDLE;
         end
      endcase
   end

   // sign fix-up and range check on the finished magnitude
   assign neg  = lsgn_ff ^ bsgn_ff;
   assign big  = (op_ff == rpn_alu_pkg::CMD_MUL) && (acc_ff != '0);
   assign fits = neg ? (!lo_ff[rpn_alu_pkg::DATA_W-1] || (lo_ff == rpn_alu_pkg::INT_MIN_MAG))
                     : !lo_ff[rpn_alu_pkg::DATA_W-1];

   always_comb begin
      alu_rsp.done   = (state_ff == A_FIX);
      alu_rsp.status = rpn_alu_pkg::ST_OK;
      alu_rsp.value  = '0;
      unique case (op_ff)
         rpn_alu_pkg::CMD_ADD, rpn_alu_pkg::CMD_SUB: begin
            if ((lsgn_ff == bsgn_ff) && (lo_ff[rpn_alu_pkg::DATA_W-1] != lsgn_ff)) begin
               alu_rsp.status = lsgn_ff ? rpn_alu_pkg::ST_UNDER : rpn_alu_pkg::ST_OVER;
            end else begin
               alu_rsp.value = lo_ff;
            end
         end
         rpn_alu_pkg::CMD_MUL, rpn_alu_pkg::CMD_DIV: begin
            if (!big && fits) begin
               alu_rsp.value = neg ? (~lo_ff + 1'b1) : lo_ff;
            end else begin
               alu_rsp.status = neg ? rpn_alu_pkg::ST_UNDER : rpn_alu_pkg::ST_OVER;
            end
         end
         default: begin
            alu_rsp.status = rpn_alu_pkg::ST_UNKNOWN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff    <= op_in;
      acc_ff   <= acc_in;
      lo_ff    <= lo_in;
      rhs_ff   <= rhs_in;
      carry_ff <= carry_in;
      lsgn_ff  <= lsgn_in;
      bsgn_ff  <= bsgn_in;
      cnt_ff   <= cnt_in;
   end

endmodule

### rtl/rpn_checked_int_alu_top.sv
// rpn integer unit top: value stack, command sequencing and result register
// push and every refused command go from acceptance through the read and done states;
// add, subtract, multiply and divide also run the alu (32 bit-serial steps) in between
// one command is taken at a time: req_stall stays high until the last one has committed
// the result register lets a new command be accepted while the last beat is stalled
// reset clears the stack count and the sequencer, the stack memory itself is not cleared
module rpn_checked_int_alu_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_command,
   input  logic signed [31:0]  req_push_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_status,
   output logic signed [31:0]  rsp_result_value,
   output logic [4:0]          rsp_stack_depth
);

   // sequencer: accept, read the two top entries, run the alu for arithmetic, commit
   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_READ = 4'b0010,
      S_EXEC = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type                             state_ff, state_in;
   rpn_alu_pkg::cmd_type                  cmd_ff, cmd_in;
   logic [rpn_alu_pkg::DATA_W-1:0]        pv_ff, pv_in;
   rpn_alu_pkg::status_type               pst_ff, pst_in;
   logic [rpn_alu_pkg::DATA_W-1:0]        pval_ff, pval_in;
   logic [rpn_alu_pkg::CNT_W-1:0]         count_ff, count_in;

   // output register, holds a finished beat while the receiver stalls
   logic                                  rsp_valid_ff, rsp_valid_in;
   rpn_alu_pkg::status_type               rsp_status_ff, rsp_status_in;
   logic [rpn_alu_pkg::DATA_W-1:0]        rsp_value_ff, rsp_value_in;
   logic [rpn_alu_pkg::DEPTH_W-1:0]       rsp_depth_ff, rsp_depth_in;

   // value stack, two registered read ports at top and top minus one
   logic [rpn_alu_pkg::DATA_W-1:0]        stack_ff [rpn_alu_pkg::STACK_DEPTH];
   logic [rpn_alu_pkg::DATA_W-1:0]        rd_top_ff, rd_next_ff;
   logic                                  mem_we;
   logic [rpn_alu_pkg::ADDR_W-1:0]        mem_waddr;
   logic [rpn_alu_pkg::DATA_W-1:0]        mem_wdata;
   logic [rpn_alu_pkg::ADDR_W-1:0]        rd_top_addr, rd_next_addr;

   rpn_alu_pkg::alu_req_type              alu_req;
   rpn_alu_pkg::alu_rsp_type              alu_rsp;

   logic                                  is_arith;

   assign rd_top_addr  = rpn_alu_pkg::ADDR_W'(count_ff - 1'b1);
   assign rd_next_addr = rpn_alu_pkg::ADDR_W'(count_ff - 2'd2);

   assign is_arith = (cmd_ff == rpn_alu_pkg::CMD_ADD) || (cmd_ff == rpn_alu_pkg::CMD_SUB) ||
                     (cmd_ff == rpn_alu_pkg::CMD_MUL) || (cmd_ff == rpn_alu_pkg::CMD_DIV);

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      pv_in         = pv_ff;
      pst_in        = pst_ff;
      pval_in       = pval_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_depth_in  = rsp_depth_ff;
      mem_we        = 1'b0;
      mem_waddr     = rpn_alu_pkg::ADDR_W'(count_ff);
      mem_wdata     = pv_ff;
      alu_req.start = 1'b0;
      alu_req.op    = cmd_ff;
      alu_req.left  = rd_next_ff;
      alu_req.right = rd_top_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = rpn_alu_pkg::cmd_type'(req_command);
               pv_in    = req_push_value;
               state_in = S_READ;
            end
         end
         S_READ: begin
            // checks in order: full on push, too few operands, unknown, divide by zero
            state_in = S_DONE;
            pval_in  = '0;
            priority if (cmd_ff == rpn_alu_pkg::CMD_PUSH) begin
               if (count_ff == rpn_alu_pkg::CNT_W'(rpn_alu_pkg::STACK_DEPTH)) begin
                  pst_in = rpn_alu_pkg::ST_FULL;
               end else begin
                  pst_in  = rpn_alu_pkg::ST_OK;
                  pval_in = pv_ff;
               end
            end else if (count_ff < rpn_alu_pkg::CNT_W'(2)) begin
               pst_in = rpn_alu_pkg::ST_FEW;
            end else if (!is_arith) begin
               pst_in = rpn_alu_pkg::ST_UNKNOWN;
            end else if ((cmd_ff == rpn_alu_pkg::CMD_DIV) && (rd_top_ff == '0)) begin
               pst_in = rpn_alu_pkg::ST_DIVZERO;
            end else begin
               alu_req.start = 1'b1;
               state_in      = S_EXEC;
            end
         end
         S_EXEC: begin
            if (alu_rsp.done) begin
               pst_in   = alu_rsp.status;
               pval_in  = alu_rsp.value;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // commit stack change and beat together once the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               if (pst_ff == rpn_alu_pkg::ST_OK) begin
                  mem_we = 1'b1;
                  if (cmd_ff == rpn_alu_pkg::CMD_PUSH) begin
                     mem_waddr = rpn_alu_pkg::ADDR_W'(count_ff);
                     mem_wdata = pv_ff;
                     count_in  = count_ff + 1'b1;
                  end else begin
                     mem_waddr = rd_next_addr;
                     mem_wdata = pval_ff;
                     count_in  = count_ff - 1'b1;
                  end
               end
               rsp_valid_in  = 1'b1;
               rsp_status_in = pst_ff;
               rsp_value_in  = pval_ff;
               rsp_depth_in  = rpn_alu_pkg::DEPTH_W'(count_in);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   rpn_alu_serial u_alu (
      .clock   (clock),
      .reset   (reset),
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_ff[mem_waddr] <= mem_wdata;
      end
      rd_top_ff  <= stack_ff[rd_top_addr];
      rd_next_ff <= stack_ff[rd_next_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      pv_ff         <= pv_in;
      pst_ff        <= pst_in;
      pval_ff       <= pval_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_depth_ff  <= rsp_depth_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_stack_depth  = rsp_depth_ff;

endmodule

### test/tb.sv
// self-checking testbench for the rpn checked integer unit
`timescale 1ns / 1ps

module tb;

   // command codes the block does not decode
   localparam logic [2:0] CMD_UNK5 = 3'd5;
   localparam logic [2:0] CMD_UNK6 = 3'd6;
   localparam logic [2:0] CMD_UNK7 = 3'd7;

   localparam logic [31:0] VAL_MAX  = 32'h7fff_ffff;
   localparam logic [31:0] VAL_MIN  = 32'h8000_0000;
   localparam logic [31:0] VAL_NEG1 = 32'hffff_ffff;
   localparam longint      WIDE_MAX = 64'sd2147483647;
   localparam longint      WIDE_MIN = -64'sd2147483648;

   // two independent copies of the stack: one steers the generator, one checks the dut
   localparam int SHADOW_GEN = 0;
   localparam int SHADOW_CHK = 1;

   localparam int RANDOM_ITEMS = 950;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 60;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] operand;
   } rpn_command_type;

   typedef struct packed {
      rpn_alu_pkg::status_type status;
      logic [31:0]             value;
      logic [4:0]              depth;
   } rpn_answer_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [2:0]         req_command = rpn_alu_pkg::CMD_PUSH;
   logic signed [31:0] req_push_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [2:0]         rsp_status;
   logic signed [31:0] rsp_result_value;
   logic [4:0]         rsp_stack_depth;

   rpn_checked_int_alu_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_push_value   (req_push_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_result_value (rsp_result_value),
      .rsp_stack_depth  (rsp_stack_depth)
   );

   // stack copies, indexed by shadow
   logic [31:0]  stack_cells [2][rpn_alu_pkg::STACK_DEPTH];
   int unsigned  stack_fill [2];

   rpn_command_type command_backlog [$];
   rpn_answer_type  answers_owed [$];

   int unsigned  tb_cycles = 0;
   int unsigned  rx_cycles = 0;
   int unsigned  mismatches = 0;
   int unsigned  send_gap = 0;
   int unsigned  stall_left = 0;
   int unsigned  gap_roll;
   int unsigned  stall_roll;
   rpn_command_type next_beat;
   rpn_answer_type  want;

   // stretches with no idling on either side
   wire quiet = (tb_cycles % 1024) < 160;
   // long receiver hold-offs so that the block backs up and stalls its input
   wire rx_hold = (rx_cycles >= 1500 && rx_cycles < 1800) ||
                  (rx_cycles >= 9000 && rx_cycles < 9400);

   initial begin : clock_gen
      forever #2 clock = ~clock;
   end

   // one command applied to one stack copy, giving the beat it should produce
   function automatic rpn_answer_type rpn_evaluate(input int sel, input logic [2:0] cmd,
                                                   input logic [31:0] operand);
      rpn_answer_type ans;
      longint         lhs;
      longint         rhs;
      longint         res;
      int unsigned    n;
      n = stack_fill[sel];
      ans.status = rpn_alu_pkg::ST_OK;
      ans.value = '0;
      res = 0;
      if (cmd == rpn_alu_pkg::CMD_PUSH) begin
         if (n >= rpn_alu_pkg::STACK_DEPTH) begin
            ans.status = rpn_alu_pkg::ST_FULL;
         end else begin
            stack_cells[sel][n] = operand;
            n++;
            ans.value = operand;
         end
      end else if (n < 2) begin
         // too few operands wins over every other check, unknown codes too
         ans.status = rpn_alu_pkg::ST_FEW;
      end else begin
         rhs = longint'($signed(stack_cells[sel][n-1]));
         lhs = longint'($signed(stack_cells[sel][n-2]));
         case (cmd)
            rpn_alu_pkg::CMD_ADD: res = lhs + rhs;
            rpn_alu_pkg::CMD_SUB: res = lhs - rhs;
            rpn_alu_pkg::CMD_MUL: res = lhs * rhs;
            rpn_alu_pkg::CMD_DIV: begin
               if (rhs == 0) ans.status = rpn_alu_pkg::ST_DIVZERO;
               else res = lhs / rhs;
            end
            default: ans.status = rpn_alu_pkg::ST_UNKNOWN;
         endcase
         if (ans.status == rpn_alu_pkg::ST_OK) begin
            if (res > WIDE_MAX) begin
               ans.status = rpn_alu_pkg::ST_OVER;
            end else if (res < WIDE_MIN) begin
               ans.status = rpn_alu_pkg::ST_UNDER;
            end else begin
               n--;
               stack_cells[sel][n-1] = res[31:0];
               ans.value = res[31:0];
            end
         end
      end
      stack_fill[sel] = n;
      ans.depth = n[4:0];
      return ans;
   endfunction

   // operand mix: plain random, small signed, extremes, multiply edge, short magnitudes
   function automatic logic [31:0] pick_operand();
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = $urandom;
         4, 5, 6: v = 32'($urandom_range(0, 40)) - 32'd20;
         7: begin
            case ($urandom_range(0, 6))
               0: v = VAL_MAX;
               1: v = VAL_MIN;
               2: v = VAL_NEG1;
               3: v = 32'd0;
               4: v = 32'd1;
               5: v = VAL_MIN + 32'd1;
               default: v = VAL_MAX - 32'd1;
            endcase
         end
         8: begin
            // square root of the positive limit sits here
            v = 32'd46340 + 32'($urandom_range(0, 2));
            if ($urandom_range(0, 1) != 0) v = -v;
         end
         default: begin
            v = $urandom >> $urandom_range(1, 31);
            if ($urandom_range(0, 1) != 0) v = -v;
         end
      endcase
      return v;
   endfunction

   // adds a command to the backlog and steps the generator's stack copy
   task automatic queue_cmd(input logic [2:0] cmd, input logic [31:0] operand);
      void'(rpn_evaluate(SHADOW_GEN, cmd, operand));
      command_backlog.push_back('{cmd, operand});
   endtask

   task automatic flag_mismatch(input string what);
      mismatches++;
      $display("tb: mismatch at %0t ns: %s", $time, what);
   endtask

   // cycle count, reset release and the overall timeout
   always @(posedge clock) begin
      tb_cycles <= tb_cycles + 1;
      if (tb_cycles == 1) reset <= 1'b0;
      if (tb_cycles == CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   // driver: the prediction is taken at the edge where a beat is accepted, then the
   // next beat (or an idle gap) is set up; a stalled beat is held untouched
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_valid && !req_stall)
            answers_owed.push_back(rpn_evaluate(SHADOW_CHK, req_command, req_push_value));
         if (!(req_valid && req_stall)) begin
            if (send_gap != 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (command_backlog.size() != 0) begin
               next_beat = command_backlog.pop_front();
               req_valid <= 1'b1;
               req_command <= next_beat.cmd;
               req_push_value <= next_beat.operand;
               // gap that follows this beat once it is taken: mostly none or short
               gap_roll = $urandom_range(0, 99);
               if (quiet || gap_roll < 55) send_gap <= 0;
               else if (gap_roll < 92) send_gap <= $urandom_range(1, 3);
               else send_gap <= $urandom_range(8, 40);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver back-pressure, counted in its own cycles
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
         rx_cycles <= 0;
      end else begin
         rx_cycles <= rx_cycles + 1;
         if (rx_hold) begin
            rsp_stall <= 1'b1;
         end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
         end else if (quiet) begin
            rsp_stall <= 1'b0;
         end else begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 70) begin
               rsp_stall <= 1'b0;
            end else if (stall_roll < 93) begin
               rsp_stall <= 1'b1;
               stall_left <= $urandom_range(0, 2);
            end else begin
               rsp_stall <= 1'b1;
               stall_left <= $urandom_range(10, 40);
            end
         end
      end
   end

   // monitor: every accepted result beat against the oldest prediction, field by field
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (answers_owed.size() == 0) begin
            flag_mismatch("result beat with nothing outstanding");
         end else begin
            want = answers_owed.pop_front();
            if (rsp_status !== want.status)
               flag_mismatch($sformatf("status got %0d want %0d", rsp_status, want.status));
            if (rsp_result_value !== want.value)
               flag_mismatch($sformatf("value got %h want %h", rsp_result_value, want.value));
            if (rsp_stack_depth !== want.depth)
               flag_mismatch($sformatf("depth got %0d want %0d", rsp_stack_depth, want.depth));
         end
      end
   end

   initial begin : stimulus
      int unsigned push_bias;
      int unsigned roll;
      int unsigned op_pick;
      stack_fill[SHADOW_GEN] = 0;
      stack_fill[SHADOW_CHK] = 0;

      // directed: too few operands on an empty and a single-entry stack
      queue_cmd(rpn_alu_pkg::CMD_ADD, VAL_NEG1);
      queue_cmd(CMD_UNK7, 32'd0);
      queue_cmd(rpn_alu_pkg::CMD_PUSH, 32'd0);
      queue_cmd(rpn_alu_pkg::CMD_DIV, 32'd0);
      // 0 - INT_MIN, INT_MIN / -1 and INT_MIN * -1 all overflow
      queue_cmd(rpn_alu_pkg::CMD_PUSH, VAL_MIN);
      queue_cmd(rpn_alu_pkg::CMD_SUB, 32'd0);
      queue_cmd(rpn_alu_pkg::CMD_PUSH, VAL_NEG1);
      queue_cmd(rpn_alu_pkg::CMD_DIV, 32'd0);
      queue_cmd(rpn_alu_pkg::CMD_MUL, 32'd0);
      // unknown code with operands present, then an underflowing add
      queue_cmd(CMD_UNK5, 32'd0);
      queue_cmd(rpn_alu_pkg::CMD_ADD, 32'd0);
      // divide by zero, then a good subtract
      queue_cmd(rpn_alu_pkg::CMD_PUSH, 32'd0);
      queue_cmd(rpn_alu_pkg::CMD_DIV, 32'd0);
      queue_cmd(rpn_alu_pkg::CMD_SUB, 32'd0);
      // -7 / 2 truncates toward zero
      queue_cmd(rpn_alu_pkg::CMD_PUSH, -32'sd7);
      queue_cmd(rpn_alu_pkg::CMD_PUSH, 32'd2);
      queue_cmd(rpn_alu_pkg::CMD_DIV, 32'd0);
      queue_cmd(rpn_alu_pkg::CMD_PUSH, VAL_MAX);
      queue_cmd(rpn_alu_pkg::CMD_MUL, 32'd0);
      queue_cmd(rpn_alu_pkg::CMD_ADD, 32'd0);
      queue_cmd(CMD_UNK6, VAL_NEG1);
      // fill to the top with extreme patterns, push once more onto a full stack
      for (int k = 0; k < 12; k++) begin
         case (k % 4)
            0: queue_cmd(rpn_alu_pkg::CMD_PUSH, VAL_MAX);
            1: queue_cmd(rpn_alu_pkg::CMD_PUSH, VAL_MIN);
            2: queue_cmd(rpn_alu_pkg::CMD_PUSH, 32'h5555_5555);
            default: queue_cmd(rpn_alu_pkg::CMD_PUSH, 32'haaaa_aaaa);
         endcase
      end
      queue_cmd(rpn_alu_pkg::CMD_PUSH, 32'd1);
      queue_cmd(rpn_alu_pkg::CMD_SUB, 32'd0);

      // random: mostly well-formed push/operate traffic whose push bias drifts so the
      // depth wanders between empty and full, with a sprinkling of unknown codes
      push_bias = 50;
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k % 40 == 0) push_bias = $urandom_range(20, 80);
         roll = $urandom_range(0, 99);
         if (roll < 5) begin
            queue_cmd(3'($urandom_range(CMD_UNK5, CMD_UNK7)), $urandom);
         end else if ($urandom_range(0, 99) < push_bias ||
                      (stack_fill[SHADOW_GEN] < 2 && roll < 80)) begin
            queue_cmd(rpn_alu_pkg::CMD_PUSH, pick_operand());
         end else begin
            op_pick = $urandom_range(rpn_alu_pkg::CMD_ADD, rpn_alu_pkg::CMD_DIV);
            queue_cmd(op_pick[2:0], pick_operand());
         end
      end

      // all beats sent and answered, then a quiet spell to catch stray results
      while (command_backlog.size() != 0 || req_valid || answers_owed.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
